// ----- hw/rtl/length_prefixed_frame_decoder_assert.svh -----
// Assertion macros for the frame decoder.
// Expects clk and rst (synchronous, active high) in the scope of each use.
`ifndef LENGTH_PREFIXED_FRAME_DECODER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lpfd_pkg.sv -----
// Shared types and constants for the length-prefixed frame decoder.
// No dependencies.
package lpfd_pkg;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_OVERSIZE = 2'd2;

  localparam logic [1:0]  HDR_LAST_IDX    = 2'd3;   // fourth header byte
  localparam logic [31:0] MAX_FRAME_RESET = 32'd1048576;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] len_t;

  typedef struct packed {
    logic [1:0] kind;
    byte_t      data_byte;
    logic       frame_last;
  } res_t;

endpackage

// ----- hw/rtl/lpfd_ifs.sv -----
// Channel interfaces of the frame decoder: stream bytes, results, config writes.
// Depends on lpfd_pkg.
interface lpfd_byte_if;
  import lpfd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lpfd_res_if;
  import lpfd_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  byte_t      data_byte;
  logic       frame_last;
  modport source (output valid, output kind, output data_byte, output frame_last, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_last, output ready);
endinterface

interface lpfd_cfg_if;
  import lpfd_pkg::*;
  logic valid;
  logic ready;
  len_t max_frame_bytes;
  modport source (output valid, output max_frame_bytes, input ready);
  modport sink (input valid, input max_frame_bytes, output ready);
endinterface

// ----- hw/rtl/lpfd_in_stage.sv -----
// Input register for the stream byte channel.
// Depends on lpfd_pkg and lpfd_byte_if.
module lpfd_in_stage (
  input  logic               clk,
  input  logic               rst,
  lpfd_byte_if.sink          byte_stream,
  input  logic               take,
  output logic               hold_valid,
  output lpfd_pkg::byte_t    hold_byte
);
  import lpfd_pkg::*;

  // Refill in the same cycle the parser drains the held item.
  assign byte_stream.ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      hold_valid <= byte_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      hold_byte <= byte_stream.in_byte;
    end
  end

endmodule

// ----- hw/rtl/lpfd_parser.sv -----
// Header/payload parser with the result register.
// Depends on lpfd_pkg, lpfd_res_if and the assertion macro header.
`include "length_prefixed_frame_decoder_assert.svh"

module lpfd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               hold_valid,
  input  lpfd_pkg::byte_t    hold_byte,
  input  lpfd_pkg::len_t     max_frame_bytes,
  output logic               take,
  lpfd_res_if.source         results
);
  import lpfd_pkg::*;

  logic [1:0] header_index, header_index_next;
  len_t       length_accum, length_accum_next;
  len_t       bytes_left, bytes_left_next;
  logic       in_payload, in_payload_next;
  logic       res_valid, res_valid_next;
  res_t       res, res_next;

  len_t       acc;
  len_t       left_dec;
  logic       emit;

  assign take = hold_valid && (!res_valid || results.ready);

  always_comb begin
    header_index_next = header_index;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    in_payload_next   = in_payload;
    res_next          = res;
    emit              = 1'b0;
    acc      = length_accum | ({24'd0, hold_byte} << {header_index, 3'b000});
    left_dec = bytes_left - 32'd1;

    if (take) begin
      if (in_payload) begin
        bytes_left_next = left_dec;
        in_payload_next = (left_dec != 32'd0);
        emit            = 1'b1;
        res_next        = '{kind: KIND_PAYLOAD, data_byte: hold_byte,
                            frame_last: (left_dec == 32'd0)};
      end else begin
        header_index_next = header_index + 2'd1;
        if (header_index == HDR_LAST_IDX) begin
          length_accum_next = '0;
          if (acc > max_frame_bytes) begin
            // drop the length, next byte starts a new header
            emit     = 1'b1;
            res_next = '{kind: KIND_OVERSIZE, data_byte: 8'd0, frame_last: 1'b0};
          end else if (acc == 32'd0) begin
            emit     = 1'b1;
            res_next = '{kind: KIND_EMPTY, data_byte: 8'd0, frame_last: 1'b1};
          end else begin
            bytes_left_next = acc;
            in_payload_next = 1'b1;
          end
        end else begin
          length_accum_next = acc;
        end
      end
    end

    if (take) begin
      res_valid_next = emit;
    end else if (results.ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index <= '0;
      length_accum <= '0;
      bytes_left   <= '0;
      in_payload   <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      header_index <= header_index_next;
      length_accum <= length_accum_next;
      bytes_left   <= bytes_left_next;
      in_payload   <= in_payload_next;
      res_valid    <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  assign results.valid      = res_valid;
  assign results.kind       = res.kind;
  assign results.data_byte  = res.data_byte;
  assign results.frame_last = res.frame_last;

  `LPFD_ASSERT_NOW(a_payload_state, in_payload, (header_index == 2'd0) && (bytes_left != 32'd0), "payload state with header progress or no bytes left")
  `LPFD_ASSERT_NEXT(a_last_ends_frame, take && in_payload && (bytes_left == 32'd1), !in_payload && res_valid && res.frame_last, "final payload byte did not close the frame")
  `LPFD_ASSERT_NOW(a_oversize_fields, res_valid && (res.kind == KIND_OVERSIZE), (res.data_byte == 8'd0) && !res.frame_last, "oversize item carries data or last")

endmodule

// ----- hw/rtl/length_prefixed_frame_decoder.sv -----
// Top level of the length-prefixed frame decoder.
// Depends on lpfd_pkg, the channel interfaces, lpfd_in_stage and lpfd_parser.
//
// Usage:
//   byte_stream carries the received stream one byte per item. Each frame is
//   a 4-byte little-endian length followed by that many payload bytes.
//   results gives one item per payload byte (kind payload, frame_last on the
//   final byte), one empty-frame item for a zero length, or one oversize item
//   when a length exceeds max_frame_bytes; after oversize the next byte is
//   read as the start of a new header. Header bytes give no item otherwise.
//   cfg writes max_frame_bytes; it is always ready. Write it only while idle.
// Timing:
//   An accepted byte sits in the input register and is parsed into the
//   result register once that is free to take it. One byte per cycle is
//   sustained while results is ready; the parse is 32-bit compares and a
//   decrement between the two registers.
// Reset: parser expects a header, both registers empty, max_frame_bytes 1048576.
// Stall: a held result waits; the input register fills, then byte_stream.ready
//   drops until results drains.
module length_prefixed_frame_decoder (
  input  logic       clk,
  input  logic       rst,
  lpfd_byte_if.sink  byte_stream,
  lpfd_res_if.source results,
  lpfd_cfg_if.sink   cfg
);
  import lpfd_pkg::*;

  len_t  max_frame_bytes;
  logic  take;
  logic  hold_valid;
  byte_t hold_byte;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_frame_bytes <= cfg.max_frame_bytes;
    end
  end

  lpfd_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .take        (take),
    .hold_valid  (hold_valid),
    .hold_byte   (hold_byte)
  );

  lpfd_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .hold_valid      (hold_valid),
    .hold_byte       (hold_byte),
    .max_frame_bytes (max_frame_bytes),
    .take            (take),
    .results         (results)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for length_prefixed_frame_decoder: directed rows, then randomized frames.
// Depends on lpfd_pkg, the lpfd channel interfaces and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PHASE_BYTES  = 200;
  localparam int unsigned SETTLE_EDGES = 4;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned NOISE_MAX    = 64;
  localparam int          DIR_ROWS     = 24;
  localparam res_t        NO_RES       = '0;
  localparam res_t        RES_EMPTY    = '{kind: KIND_EMPTY, data_byte: 8'h00, frame_last: 1'b1};
  localparam res_t        RES_OVERSIZE = '{kind: KIND_OVERSIZE, data_byte: 8'h00, frame_last: 1'b0};
  localparam res_t        RES_FF_LAST  = '{kind: KIND_PAYLOAD, data_byte: 8'hFF, frame_last: 1'b1};
  localparam res_t        RES_11_MID   = '{kind: KIND_PAYLOAD, data_byte: 8'h11, frame_last: 1'b0};

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t op;
    len_t    value;
    logic    typed;   // expected result written in the row
    logic    has;
    res_t    want;
  } dir_row_t;

  logic clk;
  logic rst;

  lpfd_byte_if byte_ch ();
  lpfd_res_if  res_ch ();
  lpfd_cfg_if  cfg_ch ();

  length_prefixed_frame_decoder u_top (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_ch),
    .results     (res_ch),
    .cfg         (cfg_ch)
  );

  // decoder state as predicted from the accepted items
  len_t       max_len;
  logic [1:0] hdr_cnt;
  len_t       len_acc;
  len_t       body_left;
  logic       in_body;

  res_t        pending_results[$];
  int unsigned mismatches  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned tx_pct      = 0;
  int unsigned rx_pct      = 0;
  int unsigned rx_hold_req = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty frame
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b1, RES_EMPTY},
    // one-byte frame
    '{ROW_BYTE, 32'h01, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'hFF, 1'b1, 1'b1, RES_FF_LAST},
    // two-byte frame, max dropped to zero in the middle of the payload
    '{ROW_BYTE, 32'h02, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h11, 1'b1, 1'b1, RES_11_MID},
    '{ROW_CFG,  32'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h22, 1'b0, 1'b0, NO_RES},
    // zero max still takes an empty frame
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b1, 1'b1, RES_EMPTY},
    // largest length header
    '{ROW_BYTE, 32'hFF, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'hFF, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'hFF, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, 32'hFF, 1'b1, 1'b1, RES_OVERSIZE}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 25;
      default: return 50;
    endcase
  endfunction

  // Advances the predicted state by one stream byte; returns 1 when a result is due.
  function automatic logic decode_byte(input byte_t b, output res_t r);
    len_t total;
    r = NO_RES;
    if (in_body) begin
      body_left    = body_left - 1;
      r.kind       = KIND_PAYLOAD;
      r.data_byte  = b;
      r.frame_last = (body_left == 0);
      in_body      = (body_left != 0);
      return 1'b1;
    end
    len_acc = len_acc | (len_t'(b) << {hdr_cnt, 3'b000});
    hdr_cnt = hdr_cnt + 2'd1;
    if (hdr_cnt != 2'd0) return 1'b0;
    total   = len_acc;
    len_acc = '0;
    if (total > max_len) begin
      r = RES_OVERSIZE;
      return 1'b1;
    end
    if (total == 0) begin
      r = RES_EMPTY;
      return 1'b1;
    end
    body_left = total;
    in_body   = 1'b1;
    return 1'b0;
  endfunction

  task automatic push_byte(input byte_t b, input logic typed, input logic typed_has,
                           input res_t typed_res);
    int unsigned gap;
    res_t        r;
    logic        has;
    gap = pick_gap(tx_pct);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    bytes_sent++;
    has = decode_byte(b, r);
    if (typed) begin
      has = typed_has;
      r   = typed_res;
    end
    if (has) pending_results.insert(pending_results.size(), r);
  endtask

  // Sender goes quiet until every expected item is back and the pipe is empty.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_EDGES) @(posedge clk);
  endtask

  task automatic write_max(input len_t v);
    settle();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.max_frame_bytes <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    max_len = v;
  endtask

  // Finishes a partial header with zeros or a payload with random bytes.
  task automatic realign();
    while (in_body || hdr_cnt != 2'd0)
      push_byte(in_body ? byte_t'($urandom) : 8'h00, 1'b0, 1'b0, NO_RES);
  endtask

  task automatic send_frame_or_noise();
    int unsigned pick;
    int unsigned cap;
    int unsigned i;
    len_t        len;
    pick = $urandom_range(99);
    // stray bytes break the framing; only safe while accepted lengths stay short
    if (max_len <= NOISE_MAX && pick < 15) begin
      repeat ($urandom_range(6, 1)) push_byte(byte_t'($urandom), 1'b0, 1'b0, NO_RES);
      return;
    end
    realign();
    pick = $urandom_range(99);
    if (pick < 10) begin
      len = '0;
    end else if (pick < 28 && max_len != 32'hFFFF_FFFF) begin
      if ($urandom_range(1) == 0) len = max_len + 1;
      else len = max_len + 1 + ($urandom % (32'hFFFF_FFFF - max_len));
    end else begin
      cap = (max_len < 24) ? max_len : 24;
      if (cap == 0) len = '0;
      else if (max_len >= 300 && $urandom_range(49) == 0) len = $urandom_range(300, 100);
      else if ($urandom_range(4) == 0) len = cap;
      else len = $urandom_range(cap, 1);
    end
    for (i = 0; i < 4; i++) push_byte(len[8*i +: 8], 1'b0, 1'b0, NO_RES);
    if (len != 0 && len <= max_len)
      for (i = 0; i < len; i++) push_byte(byte_t'($urandom), 1'b0, 1'b0, NO_RES);
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  initial begin : result_sink
    int unsigned gap_left;
    int unsigned hold_left;
    res_t        want;
    gap_left = 0;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, kind %0d data %0d last %0d", $time,
                   res_ch.kind, res_ch.data_byte, res_ch.frame_last);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(res_ch.kind));
          check_field("data_byte", want.data_byte, res_ch.data_byte);
          check_field("frame_last", 8'(want.frame_last), 8'(res_ch.frame_last));
        end
      end
      if (rx_hold_req != 0) begin
        hold_left = rx_hold_req;
        rx_hold_req <= 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        gap_left = pick_gap(rx_pct);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout, %0d items still expected", $time, pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int          i;
    int          p;
    int unsigned phase_start;
    logic        paused;
    len_t        phase_max [8];
    rst                    <= 1'b1;
    byte_ch.valid          <= 1'b0;
    byte_ch.in_byte        <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.max_frame_bytes <= '0;
    max_len   = MAX_FRAME_RESET;
    hdr_cnt   = '0;
    len_acc   = '0;
    body_left = '0;
    in_body   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_pct = 15;
    rx_pct = 15;
    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].op == ROW_CFG) write_max(dir_rows[i].value);
      else push_byte(dir_rows[i].value[7:0], dir_rows[i].typed, dir_rows[i].has,
                     dir_rows[i].want);
    end

    phase_max = '{32'd16, 32'd0, 32'd1, 32'd3, 32'd64, 32'hFFFF_FFFF,
                  len_t'($urandom), len_t'($urandom_range(48, 4))};
    paused = 1'b0;
    for (p = 0; p < 8; p++) begin
      write_max(phase_max[p]);
      tx_pct = (p == 0) ? 0 : pick_idle_pct();
      rx_pct = (p == 0) ? 0 : pick_idle_pct();
      if (p == 4) begin
        // sink holds off while bytes keep coming, so the input side backs up
        tx_pct = 0;
        rx_pct = 0;
        rx_hold_req <= HOLD_CYCLES;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_frame_or_noise();
        if (p == 6 && !paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
          settle();
          paused = 1'b1;
        end
      end
      realign();
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
